### design/spq_pkg.sv
`default_nettype none
package spq_pkg;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned WEIGHT_BITS = 16;
  localparam int unsigned TAG_BITS    = 8;
  localparam int unsigned CNT_BITS    = $clog2(DEPTH + 1);

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    op_e                           op;
    logic [TAG_BITS-1:0]           tag;
    logic signed [WEIGHT_BITS-1:0] weight;
  } in_req_t;

  typedef struct packed {
    logic [TAG_BITS-1:0]           head_tag;
    logic signed [WEIGHT_BITS-1:0] head_weight;
    logic [CNT_BITS-1:0]           entry_total;
    logic                          is_empty;
    status_e                       status;
  } out_req_t;

  typedef struct packed {
    logic [TAG_BITS-1:0]           tag;
    logic signed [WEIGHT_BITS-1:0] weight;
  } entry_t;

  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctrl_t;

endpackage
`default_nettype wire

### design/spq_cell.sv
`default_nettype none
module spq_cell
  import spq_pkg::*;
(
  input  wire logic       clk_i,
  input  wire cell_ctrl_t ctrl_i,
  input  wire entry_t     new_i,
  input  wire logic       occ_i,
  input  wire logic       prev_ge_i,
  input  wire entry_t     prev_entry_i,
  input  wire entry_t     next_entry_i,
  output logic            ge_o,
  output entry_t          entry_o,
  output entry_t          entry_d_o
);

  entry_t entry_q;
  entry_t entry_d;

  // this slot holds its place on insert when it is at least as heavy
  assign ge_o = occ_i && ($signed(entry_q.weight) >= $signed(new_i.weight));

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.deq) begin
      entry_d = next_entry_i;
    end else if (ctrl_i.enq && !ge_o) begin
      if (prev_ge_i) begin
        entry_d = new_i;
      end else begin
        entry_d = prev_entry_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o   = entry_q;
  assign entry_d_o = entry_d;

endmodule
`default_nettype wire

### design/sorted_priority_queue.sv
// channel  direction  handshake              payload
// in       input      in_valid_i / in_stall_o  in_req_i  (op, tag, weight)
// out      output     out_valid_o / out_stall_i out_req_o (head, total, empty, status)
//
// one request per cycle while in_stall_o is low; its result is registered and appears in the cycle after acceptance
// a row of DEPTH compare-and-shift cells updates in parallel each cycle
// in_stall_o is high only while a result waits and out_stall_i is high
// rst_ni clears the entry count and the output valid; slot contents are not reset
`default_nettype none
module sorted_priority_queue
  import spq_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_req_t  in_req_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_req_t      out_req_o
);

  logic [CNT_BITS-1:0] count_q, count_d;
  logic                out_valid_q, out_valid_d;
  out_req_t            out_req_q, out_req_d;

  logic       accept, full, empty;
  cell_ctrl_t ctrl;
  entry_t     new_entry;
  entry_t     entry_cur [DEPTH];
  entry_t     entry_nxt [DEPTH];
  logic       ge        [DEPTH];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CNT_BITS'(DEPTH));
  assign empty      = (count_q == '0);

  assign ctrl.enq  = accept && (in_req_i.op == OP_ENQ) && !full;
  assign ctrl.deq  = accept && (in_req_i.op == OP_DEQ) && !empty;
  assign new_entry = '{tag: in_req_i.tag, weight: in_req_i.weight};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   occ, prev_ge;
    entry_t prev_entry, next_entry;

    assign occ = (CNT_BITS'(i) < count_q);

    if (i == 0) begin : g_first
      assign prev_ge    = 1'b1;
      assign prev_entry = new_entry;
    end else begin : g_mid
      assign prev_ge    = ge[i-1];
      assign prev_entry = entry_cur[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_entry = entry_cur[i];
    end else begin : g_inner
      assign next_entry = entry_cur[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .new_i        (new_entry),
      .occ_i        (occ),
      .prev_ge_i    (prev_ge),
      .prev_entry_i (prev_entry),
      .next_entry_i (next_entry),
      .ge_o         (ge[i]),
      .entry_o      (entry_cur[i]),
      .entry_d_o    (entry_nxt[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.enq) begin
      count_d = count_q + CNT_BITS'(1);
    end else if (ctrl.deq) begin
      count_d = count_q - CNT_BITS'(1);
    end
  end

  always_comb begin
    out_req_d             = out_req_q;
    out_req_d.entry_total = count_d;
    out_req_d.is_empty    = (count_d == '0);
    if (count_d == '0) begin
      out_req_d.head_tag    = '0;
      out_req_d.head_weight = '0;
    end else begin
      out_req_d.head_tag    = entry_nxt[0].tag;
      out_req_d.head_weight = entry_nxt[0].weight;
    end
    if (in_req_i.op == OP_ENQ && full) begin
      out_req_d.status = ST_FULL;
    end else if (in_req_i.op == OP_DEQ && empty) begin
      out_req_d.status = ST_EMPTY;
    end else begin
      out_req_d.status = ST_DONE;
    end
  end

  assign out_valid_d = accept || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_req_q <= out_req_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

endmodule
`default_nettype wire

### design/spq_checker.sv
`default_nettype none
module spq_checker
  import spq_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_stall_o,
  input wire logic     out_valid_o,
  input wire logic     out_stall_i,
  input wire out_req_t out_req_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted request gave no result");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_req_o.is_empty == (out_req_o.entry_total == '0)))
    else $error("empty flag disagrees with count");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_req_o.entry_total <= CNT_BITS'(DEPTH)))
    else $error("count above depth");

  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.is_empty |->
      (out_req_o.head_tag == '0) && (out_req_o.head_weight == '0))
    else $error("head not zero when empty");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_req_o   (out_req_o)
);
`default_nettype wire

### tb/sorted_priority_queue_tb.sv
`timescale 1ns / 100ps
module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int RAND_REQS   = 1000;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 8;

  typedef enum logic [1:0] {
    RX_FLOW,
    RX_LIGHT,
    RX_HEAVY,
    RX_HOLD
  } rx_mode_e;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  in_req_t  in_req_i    = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  out_req_t out_req_o;

  sorted_priority_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  in_req_t  request_backlog[$];
  bit       backlog_sync[$];
  out_req_t head_reports_due[$];

  entry_t   model_slots[DEPTH];
  int       model_count    = 0;
  int       mismatch_count = 0;
  int       cycle_count    = 0;
  int       burst_left     = 1;
  int       gap_left       = 0;
  int       rx_cycles      = 0;
  int       rx_left        = 0;
  rx_mode_e rx_mode        = RX_FLOW;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("sorted_priority_queue verification failed");
    $finish;
  end

  function automatic out_req_t predict_head_report(in_req_t r);
    out_req_t res;
    int       pos;
    res = '0;
    res.status = ST_DONE;
    if (r.op == OP_ENQ) begin
      if (model_count >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < model_count &&
               $signed(model_slots[pos].weight) >= $signed(r.weight)) pos++;
        for (int i = model_count; i > pos; i--) model_slots[i] = model_slots[i-1];
        model_slots[pos].tag    = r.tag;
        model_slots[pos].weight = r.weight;
        model_count++;
      end
    end else if (model_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      for (int i = 0; i + 1 < model_count; i++) model_slots[i] = model_slots[i+1];
      model_count--;
    end
    if (model_count > 0) begin
      res.head_tag    = model_slots[0].tag;
      res.head_weight = model_slots[0].weight;
    end
    res.entry_total = CNT_BITS'(model_count);
    res.is_empty    = (model_count == 0);
    return res;
  endfunction

  function automatic void add_request(op_e op, int tag, int weight, bit sync);
    in_req_t r;
    r.op     = op;
    r.tag    = TAG_BITS'(tag);
    r.weight = WEIGHT_BITS'(weight);
    request_backlog.push_back(r);
    backlog_sync.push_back(sync);
  endfunction

  // request driver
  always @(posedge clk_i) begin : drive
    logic    send;
    in_req_t nxt;
    send = 1'b0;
    nxt  = in_req_i;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) head_reports_due.push_back(predict_head_report(in_req_i));
      if (in_valid_i && in_stall_o) begin
        send = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (request_backlog.size() != 0 &&
                   !(backlog_sync[0] && head_reports_due.size() != 0)) begin
        nxt  = request_backlog.pop_front();
        void'(backlog_sync.pop_front());
        send = 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 50);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
    end
    in_valid_i <= send;
    in_req_i   <= nxt;
  end

  // receiver stall pattern
  always @(posedge clk_i) begin : receive
    logic hold;
    int   pick;
    hold = 1'b0;
    if (rst_ni) begin
      rx_cycles++;
      if (rx_cycles == 400) begin
        rx_mode = RX_HOLD;
        rx_left = 150;
      end else if (rx_left == 0) begin
        pick = $urandom_range(0, 11);
        if (pick == 0) begin
          rx_mode = RX_HOLD;
          rx_left = $urandom_range(60, 150);
        end else begin
          rx_mode = (pick < 5) ? RX_FLOW : (pick < 9) ? RX_LIGHT : RX_HEAVY;
          rx_left = $urandom_range(10, 80);
        end
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_FLOW:  hold = 1'b0;
        RX_LIGHT: hold = ($urandom_range(0, 3) == 0);
        RX_HEAVY: hold = ($urandom_range(0, 3) != 0);
        default:  hold = 1'b1;
      endcase
    end
    out_stall_i <= hold;
  end

  // result monitor
  always @(posedge clk_i) begin : monitor
    out_req_t exp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (head_reports_due.size() == 0) begin
        $error("unexpected result: head_tag %0d head_weight %0d entry_total %0d",
               out_req_o.head_tag, out_req_o.head_weight, out_req_o.entry_total);
        mismatch_count++;
      end else begin
        exp = head_reports_due.pop_front();
        if (out_req_o.head_tag !== exp.head_tag) begin
          $error("head_tag expected %0d actual %0d", exp.head_tag, out_req_o.head_tag);
          mismatch_count++;
        end
        if (out_req_o.head_weight !== exp.head_weight) begin
          $error("head_weight expected %0d actual %0d", exp.head_weight,
                 out_req_o.head_weight);
          mismatch_count++;
        end
        if (out_req_o.entry_total !== exp.entry_total) begin
          $error("entry_total expected %0d actual %0d", exp.entry_total,
                 out_req_o.entry_total);
          mismatch_count++;
        end
        if (out_req_o.is_empty !== exp.is_empty) begin
          $error("is_empty expected %0d actual %0d", exp.is_empty, out_req_o.is_empty);
          mismatch_count++;
        end
        if (out_req_o.status !== exp.status) begin
          $error("status expected %0d actual %0d", exp.status, out_req_o.status);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus
    int n_rand;
    int seg_len;
    int enq_pct;
    int weight;
    op_e op;
    // directed
    add_request(OP_DEQ, 8'hff, 32'h7fff, 1'b0);
    add_request(OP_ENQ, 0, 0, 1'b0);
    add_request(OP_ENQ, 255, 32767, 1'b0);
    add_request(OP_ENQ, 8'haa, -32768, 1'b0);
    add_request(OP_ENQ, 8'h55, 0, 1'b0);
    add_request(OP_ENQ, 1, -1, 1'b0);
    add_request(OP_ENQ, 2, 1, 1'b0);
    for (int i = 0; i < 10; i++) add_request(OP_ENQ, 16 + i, 100, 1'b0);
    add_request(OP_ENQ, 8'h77, 32767, 1'b0);
    add_request(OP_DEQ, 0, 0, 1'b0);
    add_request(OP_ENQ, 8'h3c, 32767, 1'b0);
    add_request(OP_ENQ, 8'hc3, -32768, 1'b0);
    add_request(OP_DEQ, 8'h5a, -1, 1'b0);
    // random
    n_rand = 0;
    while (n_rand < RAND_REQS) begin
      seg_len = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0:       enq_pct = 25;
        1:       enq_pct = 50;
        default: enq_pct = 80;
      endcase
      repeat (seg_len) begin
        op = ($urandom_range(1, 100) <= enq_pct) ? OP_ENQ : OP_DEQ;
        case ($urandom_range(0, 3))
          0:       weight = int'($urandom_range(0, 4)) - 2;
          1:       weight = $urandom_range(0, 1) ? 32767 : -32768;
          default: weight = $urandom;
        endcase
        add_request(op, $urandom_range(0, 255), weight,
                    n_rand == 0 || $urandom_range(0, 99) == 0);
        n_rand++;
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_backlog.size() != 0 || in_valid_i || head_reports_due.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("sorted_priority_queue verification clean");
    end else begin
      $display("sorted_priority_queue verification failed");
    end
    $finish;
  end

endmodule

### sim.f
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue.sv
design/spq_checker.sv
tb/sorted_priority_queue_tb.sv
